### hw/rtl/lcgd_pkg.sv
// shared types, result codes and the permutation table of the gluing decoder
package lcgd_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned CNT_W = 7;
	localparam logic [CHAR_W-1:0] MAX_TETS = 8'd93;
	localparam logic [CHAR_W-1:0] PERM_LAST = 8'd23;

	localparam logic [2:0] KIND_COUNT = 3'd0;
	localparam logic [2:0] KIND_FLAG = 3'd1;
	localparam logic [2:0] KIND_TETIDX = 3'd2;
	localparam logic [2:0] KIND_PERM = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_MAX = 1'b1;

	// group of results produced by one character; cnt is 0..8
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic [7:0] pos;
		logic [3:0] cnt;
		logic       last;
	} batch_t;

	function automatic logic [7:0] perm_code(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0: r = 8'd27;
			5'd1: r = 8'd30;
			5'd2: r = 8'd39;
			5'd3: r = 8'd45;
			5'd4: r = 8'd54;
			5'd5: r = 8'd57;
			5'd6: r = 8'd75;
			5'd7: r = 8'd78;
			5'd8: r = 8'd99;
			5'd9: r = 8'd108;
			5'd10: r = 8'd114;
			5'd11: r = 8'd120;
			5'd12: r = 8'd135;
			5'd13: r = 8'd141;
			5'd14: r = 8'd147;
			5'd15: r = 8'd156;
			5'd16: r = 8'd177;
			5'd17: r = 8'd180;
			5'd18: r = 8'd198;
			5'd19: r = 8'd201;
			5'd20: r = 8'd210;
			5'd21: r = 8'd216;
			5'd22: r = 8'd225;
			5'd23: r = 8'd228;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/letter_coded_gluing_decoder_core.sv
// top level of the letter-coded gluing decoder: input register, registers, output stream
// a character is registered in the input stage, and its group is then loaded into the result register
// throughput: one character per cycle while each yields at most one result and m_tready is high; a nybble
//   pair's second character holds the result register for up to eight results
// the result register takes the next group while its last result is being taken
// reset: asynchronous, active low; header phase, registers to base 97 and max 25
module letter_coded_gluing_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] value, [15:8] position
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast,   // last result of a record or error
	// register write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	// configuration registers
	logic [7:0] base_q;
	logic [6:0] max_q;

	// input register stage
	logic [7:0] char_s1;
	logic       valid_s1;

	logic             take;
	logic             load_ready;
	lcgd_pkg::batch_t batch;
	logic [2:0]       out_kind;
	logic [7:0]       out_value;
	logic [7:0]       out_pos;
	logic [3:0]       cur_cnt;
	logic [2:0]       cur_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 8'd97;
			max_q <= 7'd25;
		end else if (cfg_we) begin
			case (cfg_index)
				lcgd_pkg::REG_BASE: base_q <= cfg_data;
				lcgd_pkg::REG_MAX: max_q <= cfg_data[6:0];
				default: base_q <= base_q;
			endcase
		end
	end

	// the staged character moves on when the result register can take its group
	assign take = valid_s1 && load_ready;
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	// section tracking and the results of one character
	lcgd_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.char_in        (char_s1),
		.base_character (base_q),
		.max_tetrahedra (max_q),
		.batch          (batch)
	);

	// result register, one transaction per cycle while m_tready is high
	lcgd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.batch      (batch),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_value  (out_value),
		.out_pos    (out_pos),
		.out_last   (m_tlast),
		.cur_cnt    (cur_cnt),
		.cur_idx    (cur_idx)
	);

	assign m_tdata = {out_pos, out_value};
	assign m_tuser = out_kind;

	// a pending group always has a result left to send
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, cur_idx} < cur_cnt))
		else $error("result index beyond group size");

	// only permutation and error results close a record
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
			(m_tuser == lcgd_pkg::KIND_PERM || m_tuser == lcgd_pkg::KIND_ERROR))
		else $error("last marked on a non-closing result");

	// a flag result carries a single bit
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == lcgd_pkg::KIND_FLAG) |-> (m_tdata[7:1] == 7'd0))
		else $error("flag value wider than one bit");

	// a staged character waiting on a full result register keeps it busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take) |-> m_tvalid)
		else $error("input stage stalled with result register empty");

endmodule

### hw/rtl/lcgd_decode.sv
// record parser: section state and per-character result group
module lcgd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          char_in,
	input  logic [7:0]          base_character,
	input  logic [6:0]          max_tetrahedra,
	output lcgd_pkg::batch_t    batch
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_NYBBLE,
		PH_TETIDX,
		PH_PERM
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [6:0]  tet_count_q, tet_count_d;
	logic [6:0]  section_q, section_d;
	logic [3:0]  held_q, held_d;
	logic        pending_q, pending_d;
	logic [7:0]  flags_q, flags_d;

	logic [7:0]  c;
	logic [7:0]  byte_val;
	logic [8:0]  remaining;
	logic [3:0]  flag_cnt;
	logic [7:0]  pairs_sum;
	logic [5:0]  pairs;
	logic [6:0]  section_inc;
	logic        sect_done;

	assign c = char_in - base_character;
	assign byte_val = ~({held_q, 4'b0000} + c);
	assign remaining = {1'b0, tet_count_q, 1'b0} - {1'b0, flags_q};
	assign flag_cnt = (remaining > 9'd8) ? 4'd8 : remaining[3:0];
	assign pairs_sum = {1'b0, tet_count_q} + 8'd3;
	assign pairs = pairs_sum[7:2];
	assign section_inc = section_q + 7'd1;
	assign sect_done = (section_q >= tet_count_q);

	always_comb begin
		phase_d = phase_q;
		tet_count_d = tet_count_q;
		section_d = section_q;
		held_d = held_q;
		pending_d = pending_q;
		flags_d = flags_q;
		batch = '0;
		batch.cnt = 4'd1;
		batch.value = c;
		case (phase_q)
			PH_HEADER: begin
				if ((char_in < base_character) || (c > {1'b0, max_tetrahedra}) ||
						(c > lcgd_pkg::MAX_TETS)) begin
					batch.kind = lcgd_pkg::KIND_ERROR;
					batch.last = 1'b1;
				end else begin
					batch.kind = lcgd_pkg::KIND_COUNT;
					tet_count_d = c[6:0];
					section_d = '0;
					pending_d = 1'b0;
					held_d = '0;
					flags_d = '0;
					phase_d = (c == 8'd0) ? PH_TETIDX : PH_NYBBLE;
				end
			end
			PH_NYBBLE: begin
				batch.kind = lcgd_pkg::KIND_FLAG;
				if (!pending_q) begin
					held_d = c[3:0];
					pending_d = 1'b1;
					batch.cnt = 4'd0;
				end else begin
					pending_d = 1'b0;
					batch.value = byte_val;
					batch.pos = flags_q;
					batch.cnt = flag_cnt;
					flags_d = flags_q + {4'b0000, flag_cnt};
					if ({1'b0, section_inc} >= {2'b00, pairs}) begin
						section_d = '0;
						phase_d = PH_TETIDX;
					end else begin
						section_d = section_inc;
					end
				end
			end
			PH_TETIDX: begin
				batch.kind = lcgd_pkg::KIND_TETIDX;
				batch.pos = {1'b0, section_q};
				if (sect_done) begin
					section_d = '0;
					phase_d = PH_PERM;
				end else begin
					section_d = section_inc;
				end
			end
			PH_PERM: begin
				if (c > lcgd_pkg::PERM_LAST) begin
					batch.kind = lcgd_pkg::KIND_ERROR;
					batch.last = 1'b1;
					phase_d = PH_HEADER;
					section_d = '0;
				end else begin
					batch.kind = lcgd_pkg::KIND_PERM;
					batch.value = lcgd_pkg::perm_code(c[4:0]);
					batch.pos = {1'b0, section_q};
					if (sect_done) begin
						batch.last = 1'b1;
						section_d = '0;
						phase_d = PH_HEADER;
					end else begin
						section_d = section_inc;
					end
				end
			end
			default: begin
				phase_d = PH_HEADER;
				batch.cnt = 4'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			tet_count_q <= '0;
			section_q <= '0;
			held_q <= '0;
			pending_q <= 1'b0;
			flags_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			tet_count_q <= tet_count_d;
			section_q <= section_d;
			held_q <= held_d;
			pending_q <= pending_d;
			flags_q <= flags_d;
		end
	end

endmodule

### hw/rtl/lcgd_emit.sv
// result register that plays out a group of results one per cycle while out_ready is high
module lcgd_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_valid,
	output logic             load_ready,
	input  lcgd_pkg::batch_t batch,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       out_kind,
	output logic [7:0]       out_value,
	output logic [7:0]       out_pos,
	output logic             out_last,
	output logic [3:0]       cur_cnt,
	output logic [2:0]       cur_idx
);

	lcgd_pkg::batch_t batch_q;
	logic             busy_q;
	logic [2:0]       idx_q;
	logic             final_one;
	logic             load_fire;
	logic             out_fire;

	assign final_one = ({1'b0, idx_q} == (batch_q.cnt - 4'd1));
	assign out_fire = busy_q && out_ready;
	assign load_ready = !busy_q || (out_ready && final_one);
	assign load_fire = load_valid && load_ready;

	assign out_valid = busy_q;
	assign out_kind = batch_q.kind;
	assign out_value = (batch_q.kind == lcgd_pkg::KIND_FLAG) ?
		{7'b0000000, batch_q.value[idx_q]} : batch_q.value;
	assign out_pos = batch_q.pos + {5'b00000, idx_q};
	assign out_last = batch_q.last && final_one;
	assign cur_cnt = batch_q.cnt;
	assign cur_idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (load_fire) begin
			busy_q <= (batch.cnt != 4'd0);
			idx_q <= '0;
		end else if (out_fire) begin
			if (final_one) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire) begin
			batch_q <= batch;
		end
	end

endmodule
